// ===== design/frustum_cull_test_top_assert.svh =====
// Assertion macros shared by the frustum culling RTL.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef FRUSTUM_CULL_TEST_TOP_ASSERT_SVH
`define FRUSTUM_CULL_TEST_TOP_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define FCT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/fcull_pkg.sv =====
// Types and constants shared by the frustum culling modules.
// No dependencies.
package fcull_pkg;

  // Camera-space coordinate width (scale 2^-30) and plane dot width (scale 2^-44).
  localparam int CW = 50;
  localparam int DW = 68;

  // Depth of the queues and width of their fill levels.
  localparam int QDEPTH = 4;
  localparam int QLW    = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    CFG_AXIS_RIGHT       = 3'd0,
    CFG_AXIS_UP          = 3'd1,
    CFG_AXIS_AT          = 3'd2,
    CFG_OFFSET_XY        = 3'd3,
    CFG_OFFSET_Z_NEAR    = 3'd4,
    CFG_FAR_CLIP         = 3'd5,
    CFG_SIDE_NORMALS     = 3'd6,
    CFG_VERTICAL_NORMALS = 3'd7
  } cfg_idx_t;

  typedef enum logic {
    KIND_SPHERE = 1'b0,
    KIND_BOX    = 1'b1
  } kind_t;

  typedef struct packed {
    logic [47:0] axis_right;
    logic [47:0] axis_up;
    logic [47:0] axis_at;
    logic [63:0] offset_xy;
    logic [63:0] offset_z_near;
    logic [31:0] far_clip;
    logic [63:0] side_normals;
    logic [63:0] vertical_normals;
  } cfg_t;

  // One transformed item on its way from the front to the back.
  typedef struct packed {
    kind_t                  kind;
    logic [30:0]            radius;
    logic signed [CW-1:0]   cx;
    logic signed [CW-1:0]   cy;
    logic signed [CW-1:0]   cz;
  } mid_t;

  typedef struct packed {
    logic  visible;
    kind_t kind;
  } res_t;

endpackage

// ===== design/fcull_fifo.sv =====
// Small first-in first-out queue built from registers.
// Standalone; uses the shared assertion macros.
module fcull_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [W-1:0]                 din,
  input  logic                         pop,
  output logic [W-1:0]                 dout,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   level
);
  `include "frustum_cull_test_top_assert.svh"

  localparam int LW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0] level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout  = mem_r[rd_ptr_r];
  assign empty = (level_r == '0);
  assign level = level_r;

  `FCT_ASSERT_ALWAYS(a_level_bound, level_r <= LW'(DEPTH), "queue level beyond depth")
  `FCT_ASSERT_ALWAYS(a_no_overflow, !push || pop || (level_r < LW'(DEPTH)), "push into full queue")
  `FCT_ASSERT_NEXT(a_level_up, push && !pop, level_r == $past(level_r) + 1'b1, "level did not rise")
  `FCT_ASSERT_NEXT(a_level_down, pop && !push, level_r == $past(level_r) - 1'b1, "level did not fall")

endmodule

// ===== design/fcull_front.sv =====
// Front end: accepts items and moves their point into camera space.
// Depends on fcull_pkg.
module fcull_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fcull_pkg::cfg_t              cfg,
  input  logic                         in_push,
  input  logic                         in_req_type,
  input  logic signed [31:0]           in_pos_x,
  input  logic signed [31:0]           in_pos_y,
  input  logic signed [31:0]           in_pos_z,
  input  logic [30:0]                  in_radius,
  input  logic [fcull_pkg::QLW-1:0]    q_level,
  output logic                         in_full,
  output logic                         q_push,
  output fcull_pkg::mid_t              q_data
);
  import fcull_pkg::*;

  logic                 accept;
  logic signed [31:0]   pos_v  [3];
  logic [47:0]          axis_v [3];
  logic                 valid_r, valid_nxt;
  kind_t                kind_r;
  logic [30:0]          radius_r;
  // prod_r[j][i]: input coordinate i times component j of its axis.
  logic signed [47:0]   prod_r [3][3];
  logic [31:0]          off_v  [3];
  logic signed [CW-1:0] coord  [3];

  // The queue has room for what it holds plus the item in the product stage.
  assign in_full = ((QLW+1)'(q_level) + (QLW+1)'(valid_r)) >= (QLW+1)'(QDEPTH);
  assign accept  = in_push && !in_full;
  assign valid_nxt = accept;

  assign pos_v[0]  = in_pos_x;
  assign pos_v[1]  = in_pos_y;
  assign pos_v[2]  = in_pos_z;
  assign axis_v[0] = cfg.axis_right;
  assign axis_v[1] = cfg.axis_up;
  assign axis_v[2] = cfg.axis_at;
  assign off_v[0]  = cfg.offset_xy[31:0];
  assign off_v[1]  = cfg.offset_xy[63:32];
  assign off_v[2]  = cfg.offset_z_near[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= kind_t'(in_req_type);
      radius_r <= in_radius;
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          prod_r[j][i] <= pos_v[i] * $signed(axis_v[i][16*j +: 16]);
        end
      end
    end
  end

  // The offset is Q15.16; shifting by 14 brings it to the 2^-30 scale.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      coord[j] = CW'(prod_r[j][0]) + CW'(prod_r[j][1]) + CW'(prod_r[j][2])
               + $signed({{(CW-46){off_v[j][31]}}, off_v[j], 14'b0});
    end
  end

  assign q_push        = valid_r;
  assign q_data.kind   = kind_r;
  assign q_data.radius = radius_r;
  assign q_data.cx     = coord[0];
  assign q_data.cy     = coord[1];
  assign q_data.cz     = coord[2];

endmodule

// ===== design/fcull_back.sv =====
// Back end: plane tests, box corner counters and result forming.
// Depends on fcull_pkg and the shared assertion macros.
module fcull_back #(
  parameter int BOX_CORNERS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fcull_pkg::cfg_t              cfg,
  input  logic                         q_empty,
  input  fcull_pkg::mid_t              q_data,
  input  logic [fcull_pkg::QLW-1:0]    out_level,
  output logic                         q_pop,
  output logic                         o_push,
  output fcull_pkg::res_t              o_data
);
  import fcull_pkg::*;
  `include "frustum_cull_test_top_assert.svh"

  localparam int IDXW = $clog2(BOX_CORNERS);
  localparam int PW   = CW + 16;

  logic signed [CW-1:0] cx, cy, cz, near_v, far_v, rq;
  logic signed [CW-1:0] dl [8];
  logic signed [15:0]   dn [8];
  logic                 near_hit, far_hit;

  logic                 va_r, va_nxt;
  kind_t                kind_r;
  logic                 near_r, far_r;
  logic signed [DW-1:0] rd_r;
  logic signed [PW-1:0] d_r [8];

  logic signed [DW-1:0] dot [4];
  logic signed [DW-1:0] lim;
  logic                 gt  [4];
  logic                 hit [4];
  logic [4:0]           sum_cnt [4];
  logic                 last;
  logic                 box_vis;

  logic [IDXW-1:0]      idx_r, idx_nxt;
  logic [3:0]           cnt_r [4];
  logic [3:0]           cnt_nxt [4];

  // Only pop while the result queue can take everything in flight.
  assign q_pop  = !q_empty && (((QLW+1)'(out_level) + (QLW+1)'(va_r)) < (QLW+1)'(QDEPTH));
  assign va_nxt = q_pop;

  assign cx     = q_data.cx;
  assign cy     = q_data.cy;
  assign cz     = q_data.cz;
  assign near_v = $signed({{(CW-46){cfg.offset_z_near[63]}}, cfg.offset_z_near[63:32], 14'b0});
  assign far_v  = $signed({{(CW-46){cfg.far_clip[31]}}, cfg.far_clip, 14'b0});
  assign rq     = $signed({{(CW-45){1'b0}}, q_data.radius, 14'b0});

  // Boxes test the bare depth; spheres widen it by the radius.
  assign near_hit = (q_data.kind == KIND_BOX) ? (cy < near_v) : ((cy + rq) < near_v);
  assign far_hit  = (q_data.kind == KIND_BOX) ? (cy > far_v)  : ((cy - rq) > far_v);

  always_comb begin
    dl[0] = cx; dn[0] = $signed(cfg.side_normals[15:0]);
    dl[1] = cy; dn[1] = $signed(cfg.side_normals[31:16]);
    dl[2] = cx; dn[2] = $signed(cfg.side_normals[47:32]);
    dl[3] = cy; dn[3] = $signed(cfg.side_normals[63:48]);
    dl[4] = cy; dn[4] = $signed(cfg.vertical_normals[15:0]);
    dl[5] = cz; dn[5] = $signed(cfg.vertical_normals[31:16]);
    dl[6] = cy; dn[6] = $signed(cfg.vertical_normals[47:32]);
    dl[7] = cz; dn[7] = $signed(cfg.vertical_normals[63:48]);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= q_data.kind;
      near_r <= near_hit;
      far_r  <= far_hit;
      rd_r   <= $signed({{(DW-59){1'b0}}, q_data.radius, 28'b0});
      for (int k = 0; k < 8; k++) begin
        d_r[k] <= dl[k] * dn[k];
      end
    end
  end

  // Plane dots against the radius, or against zero for box corners.
  always_comb begin
    lim = (kind_r == KIND_BOX) ? '0 : rd_r;
    for (int p = 0; p < 4; p++) begin
      dot[p] = DW'(d_r[2*p]) + DW'(d_r[2*p+1]);
      gt[p]  = dot[p] > lim;
    end
  end

  always_comb begin
    hit[0]  = near_r;
    hit[1]  = far_r;
    hit[2]  = gt[0];
    hit[3]  = gt[1];
    last    = (idx_r == IDXW'(BOX_CORNERS - 1));
    box_vis = 1'b1;
    idx_nxt = idx_r;
    for (int i = 0; i < 4; i++) begin
      sum_cnt[i] = {1'b0, cnt_r[i]} + {4'b0, hit[i]};
      cnt_nxt[i] = cnt_r[i];
      if (sum_cnt[i] >= 5'(BOX_CORNERS)) begin
        box_vis = 1'b0;
      end
    end
    if (va_r && (kind_r == KIND_BOX)) begin
      if (last) begin
        idx_nxt = '0;
        for (int i = 0; i < 4; i++) begin
          cnt_nxt[i] = '0;
        end
      end else begin
        idx_nxt = idx_r + 1'b1;
        for (int i = 0; i < 4; i++) begin
          cnt_nxt[i] = sum_cnt[i][4] ? 4'd15 : sum_cnt[i][3:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= 1'b0;
      idx_r <= '0;
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      va_r  <= va_nxt;
      idx_r <= idx_nxt;
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  assign o_push         = va_r && ((kind_r == KIND_SPHERE) || last);
  assign o_data.kind    = kind_r;
  assign o_data.visible = (kind_r == KIND_BOX) ? box_vis
                        : !(near_r || far_r || gt[0] || gt[1] || gt[2] || gt[3]);

  `FCT_ASSERT_ALWAYS(a_idx_bound, {1'b0, idx_r} < (IDXW+1)'(BOX_CORNERS), "corner index out of range")
  `FCT_ASSERT_NEXT(a_box_wrap, va_r && (kind_r == KIND_BOX) && last, (idx_r == '0) && (cnt_r[0] == '0), "box state not cleared")
  `FCT_ASSERT_ALWAYS(a_credit, ((QLW+1)'(out_level) + (QLW+1)'(va_r)) <= (QLW+1)'(QDEPTH), "result queue credit lost")

endmodule

// ===== design/frustum_cull_test_top.sv =====
// Top level of the frustum culling test: configuration registers and the
// front end, middle queue, back end and result queue. Depends on fcull_pkg.
//
//   Channel   Ports                                         Handshake
//   input     in_req_type, in_pos_x/y/z, in_radius          in_push, in_full
//   result    out_visible, out_kind                         out_empty, out_pop
//   config    cfg_index, cfg_wdata                          cfg_we
//
// One item is accepted per cycle when nothing stalls. On its way to the result
// ports an item passes, in order, the transform product registers, the middle
// queue, which takes the sums, the plane product registers and the result
// queue, which takes the compares.
// Reset (rst_n low, synchronous) empties both queues, clears the box corner
// counters and loads the default camera. A stalled result side fills the
// result queue, then the middle queue, and then raises in_full.
module frustum_cull_test_top #(
  parameter int BOX_CORNERS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input item channel.
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_req_type,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [30:0]        in_radius,
  // Result item channel.
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_visible,
  output logic               out_kind,
  // Configuration write port.
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);
  import fcull_pkg::*;

  cfg_t            cfg_r, cfg_nxt;
  logic            mid_push, mid_pop, mid_empty;
  mid_t            mid_in, mid_out;
  logic [QLW-1:0]  mid_level;
  logic            res_push, res_pop;
  res_t            res_in, res_out;
  logic [QLW-1:0]  res_level;

  // Configuration registers; the user must ensure no item is in flight while one is written (unchecked).
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_AXIS_RIGHT:       cfg_nxt.axis_right       = cfg_wdata[47:0];
        CFG_AXIS_UP:          cfg_nxt.axis_up          = cfg_wdata[47:0];
        CFG_AXIS_AT:          cfg_nxt.axis_at          = cfg_wdata[47:0];
        CFG_OFFSET_XY:        cfg_nxt.offset_xy        = cfg_wdata;
        CFG_OFFSET_Z_NEAR:    cfg_nxt.offset_z_near    = cfg_wdata;
        CFG_FAR_CLIP:         cfg_nxt.far_clip         = cfg_wdata[31:0];
        CFG_SIDE_NORMALS:     cfg_nxt.side_normals     = cfg_wdata;
        CFG_VERTICAL_NORMALS: cfg_nxt.vertical_normals = cfg_wdata;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  // The default camera looks down the identity axes with no offset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.axis_right       <= 48'h0000_0000_4000;
      cfg_r.axis_up          <= 48'h0000_4000_0000;
      cfg_r.axis_at          <= 48'h4000_0000_0000;
      cfg_r.offset_xy        <= '0;
      cfg_r.offset_z_near    <= '0;
      cfg_r.far_clip         <= 32'h7FFF_FFFF;
      cfg_r.side_normals     <= '0;
      cfg_r.vertical_normals <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fcull_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_push     (in_push),
    .in_req_type (in_req_type),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .in_pos_z    (in_pos_z),
    .in_radius   (in_radius),
    .q_level     (mid_level),
    .in_full     (in_full),
    .q_push      (mid_push),
    .q_data      (mid_in)
  );

  fcull_fifo #(
    .W     ($bits(mid_t)),
    .DEPTH (QDEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .din   (mid_in),
    .pop   (mid_pop),
    .dout  (mid_out),
    .empty (mid_empty),
    .level (mid_level)
  );

  fcull_back #(
    .BOX_CORNERS (BOX_CORNERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (mid_empty),
    .q_data    (mid_out),
    .out_level (res_level),
    .q_pop     (mid_pop),
    .o_push    (res_push),
    .o_data    (res_in)
  );

  // A pop while the result queue is empty is simply not taken.
  assign res_pop = out_pop && !out_empty;

  fcull_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (QDEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .pop   (res_pop),
    .dout  (res_out),
    .empty (out_empty),
    .level (res_level)
  );

  assign out_visible = res_out.visible;
  assign out_kind    = res_out.kind;

endmodule
